// ===== design/dtwf_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// dtwf_pkg: shared types and constants of the DDS tuning word formatter
// Holds the divider widths, the command word tags and the reset values of the
// master clock derived terms.
// -----------------------------------------------------------------------------
package dtwf_pkg;

	localparam int NUM_W = 61;              // f*2^28 + mclk*500 fits below 2^61
	localparam int DEN_W = 42;              // mclk*1000 fits below 2^42
	localparam int QUO_W = 28;              // tuning word width
	localparam int CMP_W = DEN_W + QUO_W;   // width of a shifted divisor
	localparam int PH_W  = 12;              // phase word width
	localparam int SEG_W = 14;              // payload bits of one frequency word
	localparam int PH_SH = 7;               // phase scaled by 128
	localparam int PH_X_W = 41;             // signed phase*128 plus bias

	localparam int FIFO_DEPTH = 4;

	localparam logic [31:0]      MCLK_RESET = 32'd75000000;
	localparam logic [DEN_W-1:0] CLK_MULT   = 42'd1000;
	localparam logic [DEN_W-1:0] HALF_MULT  = 42'd500;
	localparam logic [DEN_W-1:0] DEN_RESET  = 42'd75000000000;
	localparam logic [DEN_W-1:0] HALF_RESET = 42'd37500000000;

	// round(w*4096/360000) = floor((w*128 + 5625) / 11250); the bias also adds
	// a whole number of turns so the dividend stays positive
	localparam logic [DEN_W-1:0]  PH_DIV  = 42'd11250;
	localparam logic [PH_X_W-1:0] PH_BIAS = 41'd276480005625;

	localparam logic [15:0] TAG_FREQ0  = 16'h4000;
	localparam logic [15:0] TAG_FREQ1  = 16'h8000;
	localparam logic [15:0] TAG_PHASE0 = 16'hC000;
	localparam logic [15:0] TAG_PHASE1 = 16'hE000;

	localparam logic ACT_FREQ  = 1'b0;
	localparam logic ACT_PHASE = 1'b1;

	typedef struct packed {
		logic             act;
		logic             sel;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} item_t;

	typedef struct packed {
		logic             act;
		logic             sel;
		logic             clamp;
		logic [NUM_W-1:0] rem;
		logic [DEN_W-1:0] den;
		logic [QUO_W-1:0] quo;
	} dstage_t;

	typedef struct packed {
		logic             act;
		logic             sel;
		logic             clamp;
		logic [QUO_W-1:0] quo;
	} res_t;

endpackage
`default_nettype wire

// ===== design/dtwf_front.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// dtwf_front: request intake and classification
// Holds the clock register, forms dividend and divisor per request and
// queues them for the divider.
// -----------------------------------------------------------------------------
module dtwf_front #(
	parameter int DEPTH = dtwf_pkg::FIFO_DEPTH
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    cfg_valid,
	output logic                   cfg_ready,
	input  wire  [31:0]            cfg_data,
	input  wire                    push,
	output logic                   full,
	input  wire                    action,
	input  wire                    reg_select,
	input  wire  [31:0]            target_freq,
	input  wire  signed [31:0]     phase_millideg,
	output logic                   out_valid,
	input  wire                    out_ready,
	output dtwf_pkg::item_t        out_item
);
	import dtwf_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [DEN_W-1:0]  den_q;
	logic [DEN_W-1:0]  half_q;
	item_t             new_item;
	logic [PH_X_W-1:0] ph_x;
	item_t             mem_q [DEPTH];
	logic [AW-1:0]     wr_q, rd_q;
	logic [CW-1:0]     cnt_q;
	logic              wr_en, rd_en;

	assign cfg_ready = 1'b1;

	// a zero clock is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			den_q  <= DEN_RESET;
			half_q <= HALF_RESET;
		end else if (cfg_valid && cfg_data != 32'd0) begin
			den_q  <= DEN_W'({10'd0, cfg_data} * CLK_MULT);
			half_q <= DEN_W'({10'd0, cfg_data} * HALF_MULT);
		end
	end

	assign ph_x = {{(PH_X_W - 32 - PH_SH){phase_millideg[31]}}, phase_millideg,
		{PH_SH{1'b0}}} + PH_BIAS;

	always_comb begin
		new_item.act = action;
		new_item.sel = reg_select;
		if (action == ACT_FREQ) begin
			new_item.num = {1'b0, target_freq, {QUO_W{1'b0}}} + NUM_W'(half_q);
			new_item.den = den_q;
		end else begin
			new_item.num = NUM_W'(ph_x);
			new_item.den = PH_DIV;
		end
	end

	assign full      = (cnt_q == CW'(DEPTH));
	assign out_valid = (cnt_q != '0);
	assign out_item  = mem_q[rd_q];
	assign wr_en     = push && !full;
	assign rd_en     = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == AW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == AW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/dtwf_div.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// dtwf_div: pipelined restoring divider
// An overflow check stage, then one quotient bit per stage; advances as a
// whole when its tail is free.
// -----------------------------------------------------------------------------
module dtwf_div (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  dtwf_pkg::item_t  in_item,
	output logic             out_valid,
	input  wire              out_ready,
	output dtwf_pkg::res_t   out_res
);
	import dtwf_pkg::*;

	dstage_t pipe_s [QUO_W+1];
	logic    vld_s  [QUO_W+1];
	logic    en;
	logic    ovf;

	assign en       = !vld_s[QUO_W] || out_ready;
	assign in_ready = en;

	// quotient above 28 bits: saturate
	assign ovf = {{(CMP_W - NUM_W){1'b0}}, in_item.num} >= {in_item.den, {QUO_W{1'b0}}};

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s[0].act   <= in_item.act;
			pipe_s[0].sel   <= in_item.sel;
			pipe_s[0].clamp <= ovf;
			pipe_s[0].rem   <= ovf ? '0 : in_item.num;
			pipe_s[0].den   <= in_item.den;
			pipe_s[0].quo   <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_stage
		localparam int SH = QUO_W - k;
		logic [CMP_W-1:0] dsh, rem_x;
		dstage_t          nxt;

		assign dsh   = {{QUO_W{1'b0}}, pipe_s[k-1].den} << SH;
		assign rem_x = {{(CMP_W - NUM_W){1'b0}}, pipe_s[k-1].rem};

		always_comb begin
			nxt = pipe_s[k-1];
			if (rem_x >= dsh) begin
				nxt.rem     = NUM_W'(rem_x - dsh);
				nxt.quo[SH] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				pipe_s[k] <= nxt;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	assign out_valid     = vld_s[QUO_W];
	assign out_res.act   = pipe_s[QUO_W].act;
	assign out_res.sel   = pipe_s[QUO_W].sel;
	assign out_res.clamp = pipe_s[QUO_W].clamp;
	assign out_res.quo   = pipe_s[QUO_W].clamp ? {QUO_W{1'b1}} : pipe_s[QUO_W].quo;

endmodule
`default_nettype wire

// ===== design/dtwf_emit.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// dtwf_emit: command word output stage
// Holds one finished result and hands out its one or two tagged words.
// -----------------------------------------------------------------------------
module dtwf_emit (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  dtwf_pkg::res_t   in_res,
	output logic             empty,
	input  wire              pop,
	output logic [15:0]      command_word,
	output logic             last,
	output logic             clamped
);
	import dtwf_pkg::*;

	res_t res_q;
	logic vld_q;
	logic hi_q;
	logic done;

	assign last     = (res_q.act == ACT_PHASE) || hi_q;
	assign done     = vld_q && pop && last;
	assign in_ready = !vld_q || done;
	assign empty    = !vld_q;
	assign clamped  = (res_q.act == ACT_FREQ) && res_q.clamp;

	always_comb begin
		if (res_q.act == ACT_PHASE) begin
			command_word = (res_q.sel ? TAG_PHASE1 : TAG_PHASE0)
				| {{(16 - PH_W){1'b0}}, res_q.quo[PH_W-1:0]};
		end else if (hi_q) begin
			command_word = (res_q.sel ? TAG_FREQ1 : TAG_FREQ0)
				| {2'b00, res_q.quo[2*SEG_W-1:SEG_W]};
		end else begin
			command_word = (res_q.sel ? TAG_FREQ1 : TAG_FREQ0)
				| {2'b00, res_q.quo[SEG_W-1:0]};
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= in_res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			hi_q  <= 1'b0;
		end else if (in_ready) begin
			vld_q <= in_valid;
			hi_q  <= 1'b0;
		end else if (vld_q && pop) begin
			hi_q <= 1'b1;
		end
	end

endmodule
`default_nettype wire

// ===== design/dds_tuning_word_formatter_core.sv =====
// -----------------------------------------------------------------------------
// dds_tuning_word_formatter_core: DDS frequency and phase command formatter
// Path: request queue, divider overflow and quotient stages, output register.
// Throughput: one phase request a cycle while pop is held; a frequency request
// gives two words, so the two-word frequency result sets the result port rate.
// Reset: arst_n clears all control state; the clock register returns to 75 MHz.
// -----------------------------------------------------------------------------
`default_nettype none
module dds_tuning_word_formatter_core #(
	parameter int FIFO_DEPTH = dtwf_pkg::FIFO_DEPTH
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire  [31:0]       cfg_data,
	input  wire               push,
	output logic              full,
	input  wire               action,
	input  wire               reg_select,
	input  wire  [31:0]       target_freq,
	input  wire  signed [31:0] phase_millideg,
	output logic              empty,
	input  wire               pop,
	output logic [15:0]       command_word,
	output logic              last,
	output logic              clamped
);
	import dtwf_pkg::*;

	item_t q_item;
	logic  q_valid, q_ready;
	res_t  d_res;
	logic  d_valid, d_ready;

	// Front: hold the clock register, turn each request into a dividend and
	// divisor (phase folded to a positive dividend over 11250), queue it.
	dtwf_front #(
		.DEPTH(FIFO_DEPTH)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.push          (push),
		.full          (full),
		.action        (action),
		.reg_select    (reg_select),
		.target_freq   (target_freq),
		.phase_millideg(phase_millideg),
		.out_valid     (q_valid),
		.out_ready     (q_ready),
		.out_item      (q_item)
	);

	// Back: one overflow stage and 28 quotient stages; stall as one.
	dtwf_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (q_valid),
		.in_ready (q_ready),
		.in_item  (q_item),
		.out_valid(d_valid),
		.out_ready(d_ready),
		.out_res  (d_res)
	);

	// Output register: low word first, then high word, for a frequency result.
	dtwf_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (d_valid),
		.in_ready    (d_ready),
		.in_res      (d_res),
		.empty       (empty),
		.pop         (pop),
		.command_word(command_word),
		.last        (last),
		.clamped     (clamped)
	);

`ifndef SYNTHESIS
	// the high word of a frequency transaction follows its low word at once
	a_pair_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last) |=> (!empty && last
			&& command_word[15:14] == $past(command_word[15:14])))
		else $error("high frequency word missing after low word");

	a_pair_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !empty && !last) |=> (clamped == $past(clamped)))
		else $error("clamp flag differs between the two frequency words");

	a_phase_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && command_word[15:14] == 2'b11) |-> (last && !clamped))
		else $error("phase word not final or flagged clamped");
`endif

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_top: self-checking bench for the DDS tuning word formatter
// Drives frequency and phase requests through the push side, pops command
// words at random, and checks each word against a directed row's given words
// or an in-bench tuning/phase word calculation, under several clock settings.
// -----------------------------------------------------------------------------
`default_nettype none
module tb_top;
	import dtwf_pkg::*;

	localparam int DRAIN_CYCLES = 40;    // pipeline latency plus margin
	localparam int STALL_LIMIT  = 5000;  // cycles without any transaction
	localparam int RAND_ITEMS   = 584;   // per idling phase, three phases
	localparam logic [27:0] TW_MAX = 28'h0FFFFFFF;
	localparam longint FULL_TURN = 360000;

	typedef struct {
		logic [15:0] word;
		logic        last;
		logic        clamped;
	} cmd_word_t;

	typedef struct {
		bit          is_cfg;   // row writes the clock register, value in freq
		logic        act;
		logic        sel;
		logic [31:0] freq;
		logic [31:0] phase;
		bit          typed;    // expected words given in the row
		logic [15:0] w0;
		logic [15:0] w1;
		logic        clamp;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        push = 1'b0;
	logic        full;
	logic        action = ACT_FREQ;
	logic        reg_select = 1'b0;
	logic [31:0] target_freq = '0;
	logic signed [31:0] phase_millideg = '0;
	logic        empty;
	logic        pop = 1'b0;
	logic [15:0] command_word;
	logic        last;
	logic        clamped;

	cmd_word_t   pending_words[$];
	logic [31:0] mclk_hz;
	int          mismatches = 0;
	int          tx_idle_pct = 0;
	int          rx_idle_pct = 0;
	int          quiet_cycles = 0;

	dds_tuning_word_formatter_core DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.action         (action),
		.reg_select     (reg_select),
		.target_freq    (target_freq),
		.phase_millideg (phase_millideg),
		.empty          (empty),
		.pop            (pop),
		.command_word   (command_word),
		.last           (last),
		.clamped        (clamped)
	);

	always #5 clk = ~clk;

	// Work out the command words of one request and queue them in order.
	function automatic void queue_command_words(input logic act, input logic sel,
			input logic [31:0] freq, input logic [31:0] phase);
		longint unsigned num;
		longint unsigned den;
		longint unsigned tw;
		longint          p;
		longint          w;
		longint unsigned val;
		logic            clamp;
		logic [15:0]     tag;
		if (act == ACT_FREQ) begin
			tag   = sel ? TAG_FREQ1 : TAG_FREQ0;
			num   = (longint'(freq) << 28) + longint'(mclk_hz) * 500;
			den   = longint'(mclk_hz) * 1000;
			tw    = num / den;
			clamp = (tw > TW_MAX);
			if (clamp)
				tw = TW_MAX;
			pending_words.push_back('{tag | 16'(tw & 64'h3FFF), 1'b0, clamp});
			pending_words.push_back('{tag | 16'((tw >> 14) & 64'h3FFF), 1'b1, clamp});
		end else begin
			tag = sel ? TAG_PHASE1 : TAG_PHASE0;
			p   = longint'(signed'(phase));
			w   = p % FULL_TURN;
			if (w < 0)
				w += FULL_TURN;
			// a value that rounds up to a full turn wraps to zero
			val = ((longint'(w) * 4096) + 180000) / 360000;
			pending_words.push_back('{tag | 16'(val & 64'hFFF), 1'b1, 1'b0});
		end
	endfunction

	// Pop side: request a word at random, at the falling edge.
	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= rx_idle_pct);
	end

	// Check every popped word against the oldest pending one.
	always @(posedge clk) begin
		cmd_word_t exp_w;
		if (arst_n && pop && !empty) begin
			if (pending_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %h last %b clamped %b",
						command_word, last, clamped);
			end else begin
				exp_w = pending_words.pop_front();
				if (command_word !== exp_w.word || last !== exp_w.last
						|| clamped !== exp_w.clamped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word mismatch: exp %h/%b/%b got %h/%b/%b",
							exp_w.word, exp_w.last, exp_w.clamped,
							command_word, last, clamped);
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long.
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Present one request; push stays high into the next request unless
	// the sender idles first.
	task automatic send_request(input logic act, input logic sel,
			input logic [31:0] freq, input logic [31:0] phase,
			input bit typed, input logic [15:0] w0, input logic [15:0] w1,
			input logic clamp);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			push <= 1'b0;
		end
		@(negedge clk);
		push           <= 1'b1;
		action         <= act;
		reg_select     <= sel;
		target_freq    <= freq;
		phase_millideg <= phase;
		do @(posedge clk); while (full);
		if (!typed)
			queue_command_words(act, sel, freq, phase);
		else if (act == ACT_FREQ) begin
			pending_words.push_back('{w0, 1'b0, clamp});
			pending_words.push_back('{w1, 1'b1, clamp});
		end else
			pending_words.push_back('{w0, 1'b1, 1'b0});
	endtask

	// Drain the block, then write the master clock register.
	task automatic write_master_clock(input logic [31:0] value);
		@(negedge clk);
		push <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		// a zero clock is refused, the old value holds
		if (value != 0)
			mclk_hz = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_random_request();
		logic [31:0] freq;
		logic [31:0] phase;
		freq  = ($urandom_range(2) == 0) ? $urandom : $urandom_range(2000000);
		phase = ($urandom_range(2) == 0) ? $urandom
			: 32'($urandom_range(1440000)) - 32'd720000;
		send_request(1'($urandom), 1'($urandom), freq, phase, 0, '0, '0, 1'b0);
	endtask

	stim_row_t directed[] = '{
		// reset clock: zero frequency gives zero tuning words
		'{0, ACT_FREQ,  0, 32'd0,          32'd0,       1, 16'h4000, 16'h4000, 0},
		'{0, ACT_FREQ,  1, 32'd0,          32'd0,       1, 16'h8000, 16'h8000, 0},
		'{0, ACT_FREQ,  0, 32'hFFFFFFFF,   32'h5555AAAA, 0, '0, '0, 0},
		'{0, ACT_FREQ,  1, 32'd1,          32'd0,       0, '0, '0, 0},
		'{0, ACT_FREQ,  0, 32'h80000000,   32'd0,       0, '0, '0, 0},
		'{0, ACT_PHASE, 0, 32'hFFFFFFFF,   32'd0,       1, 16'hC000, '0, 0},
		'{0, ACT_PHASE, 1, 32'd0,          32'd0,       1, 16'hE000, '0, 0},
		// full turn and just below it both land on zero
		'{0, ACT_PHASE, 0, 32'd0,          32'd360000,  1, 16'hC000, '0, 0},
		'{0, ACT_PHASE, 1, 32'd0,          32'd359999,  1, 16'hE000, '0, 0},
		'{0, ACT_PHASE, 0, 32'd0,          -32'sd90000, 1, 16'hCC00, '0, 0},
		'{0, ACT_PHASE, 1, 32'd0,          32'd90000,   1, 16'hE400, '0, 0},
		'{0, ACT_PHASE, 0, 32'd0,          32'h7FFFFFFF, 0, '0, '0, 0},
		'{0, ACT_PHASE, 1, 32'd0,          32'h80000000, 0, '0, '0, 0},
		'{0, ACT_PHASE, 0, 32'd0,          32'hFFFFFFFF, 0, '0, '0, 0},
		// zero clock write is ignored
		'{1, ACT_FREQ,  0, 32'd0,          32'd0,       0, '0, '0, 0},
		'{0, ACT_FREQ,  0, 32'd123456789,  32'd0,       0, '0, '0, 0},
		// slowest clock: large requests saturate
		'{1, ACT_FREQ,  0, 32'd1,          32'd0,       0, '0, '0, 0},
		'{0, ACT_FREQ,  0, 32'hFFFFFFFF,   32'd0,       1, 16'h7FFF, 16'h7FFF, 1},
		'{0, ACT_FREQ,  1, 32'hFFFFFFFF,   32'd0,       1, 16'hBFFF, 16'hBFFF, 1},
		'{0, ACT_FREQ,  0, 32'd0,          32'd0,       1, 16'h4000, 16'h4000, 0},
		'{0, ACT_FREQ,  1, 32'd1,          32'd0,       0, '0, '0, 0},
		'{0, ACT_FREQ,  0, 32'd1000,       32'd0,       0, '0, '0, 0},
		// fastest clock
		'{1, ACT_FREQ,  0, 32'hFFFFFFFF,   32'd0,       0, '0, '0, 0},
		'{0, ACT_FREQ,  1, 32'hFFFFFFFF,   32'd0,       0, '0, '0, 0},
		'{0, ACT_FREQ,  0, 32'd1,          32'd0,       0, '0, '0, 0}
	};

	initial begin
		mclk_hz = MCLK_RESET;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (directed[i]) begin
			if (directed[i].is_cfg)
				write_master_clock(directed[i].freq);
			else
				send_request(directed[i].act, directed[i].sel, directed[i].freq,
					directed[i].phase, directed[i].typed, directed[i].w0,
					directed[i].w1, directed[i].clamp);
		end

		// three idling phases, each under a fresh clock setting
		for (int ph = 0; ph < 3; ph++) begin
			case (ph)
				0: begin
					tx_idle_pct = 11;
					rx_idle_pct = 87;
					write_master_clock($urandom_range(10000000, 1));
				end
				1: begin
					tx_idle_pct = 87;
					rx_idle_pct = 11;
					write_master_clock(MCLK_RESET);
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
					write_master_clock($urandom | 32'd1);
				end
			endcase
			for (int n = 0; n < RAND_ITEMS; n++)
				send_random_request();
		end

		@(negedge clk);
		push <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== sim.f =====
design/dtwf_pkg.sv
design/dtwf_front.sv
design/dtwf_div.sv
design/dtwf_emit.sv
design/dds_tuning_word_formatter_core.sv
tb/sv/tb_top.sv
